/* design/eiec_pkg.sv */
// Shared types, constants and helpers for the external interrupt edge controller.
`default_nettype none
package eiec_pkg;

    localparam int LINES        = 16;
    localparam int CODE_W       = 4;
    localparam int SEL_REGS     = 4;
    localparam int LINES_PER_SEL = LINES / SEL_REGS;
    localparam int IRQ_W        = 7;
    localparam int REG_IDX_W    = 3;
    localparam int APB_ADDR_W   = REG_IDX_W + 2;
    localparam int APB_DATA_W   = 32;
    localparam int IN_DATA_W    = 5 * LINES;
    localparam int OUT_DATA_W   = 24;

    // Port codes
    localparam logic [CODE_W-1:0] PORT_A = 4'd0;
    localparam logic [CODE_W-1:0] PORT_B = 4'd1;
    localparam logic [CODE_W-1:0] PORT_C = 4'd2;
    localparam logic [CODE_W-1:0] PORT_D = 4'd3;

    // Item actions
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RISE  = 3'd0,
        REG_FALL  = 3'd1,
        REG_IEN   = 3'd2,
        REG_SEL0  = 3'd3,
        REG_SEL4  = 3'd4,
        REG_SEL8  = 3'd5,
        REG_SEL12 = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [SEL_REGS-1:0][LINES-1:0] sel;
        logic [LINES-1:0]               ien;
        logic [LINES-1:0]               fall;
        logic [LINES-1:0]               rise;
    } t_cfg;

    typedef struct packed {
        logic [LINES-1:0] clear_mask;
        logic [LINES-1:0] port_d;
        logic [LINES-1:0] port_c;
        logic [LINES-1:0] port_b;
        logic [LINES-1:0] port_a;
        logic             action;
    } t_item;

    typedef struct packed {
        logic [IRQ_W-1:0] irq;
        logic [LINES-1:0] pending;
    } t_result;

    // Lines 0..4 map one to one, 5..9 and 10..15 are ORed into one request each
    function automatic logic [IRQ_W-1:0] group_requests(input logic [LINES-1:0] p);
        logic [IRQ_W-1:0] r;
        r      = {2'b00, p[4:0]};
        r[5]   = |p[9:5];
        r[6]   = |p[15:10];
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/eiec_core.sv */
// Line routing, edge detection and pending-bit state of the interrupt controller.
`default_nettype none
module eiec_core
    import eiec_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_cfg    i_cfg,
    input  wire     i_accept,
    input  t_item   i_item,
    output t_result o_result
);

    logic [LINES-1:0] r_prev_levels;
    logic [LINES-1:0] r_pending;
    logic [LINES-1:0] n_prev_levels;
    logic [LINES-1:0] n_pending;
    logic [LINES-1:0] cur_levels;
    logic [LINES-1:0] hit;

    // Route each line to the selected port pin; unused codes read as low
    always_comb begin
        logic [CODE_W-1:0] code;
        for (int n = 0; n < LINES; n++) begin
            code = i_cfg.sel[n / LINES_PER_SEL][(n % LINES_PER_SEL) * CODE_W +: CODE_W];
            case (code)
                PORT_A:  cur_levels[n] = i_item.port_a[n];
                PORT_B:  cur_levels[n] = i_item.port_b[n];
                PORT_C:  cur_levels[n] = i_item.port_c[n];
                PORT_D:  cur_levels[n] = i_item.port_d[n];
                default: cur_levels[n] = 1'b0;
            endcase
        end
    end

    assign hit = ((cur_levels & ~r_prev_levels & i_cfg.rise)
                | (~cur_levels & r_prev_levels & i_cfg.fall)) & i_cfg.ien;

    always_comb begin
        n_prev_levels = r_prev_levels;
        n_pending     = r_pending;
        if (i_item.action == ACT_CLEAR) begin
            n_pending = r_pending & ~i_item.clear_mask;
        end else begin
            n_pending     = r_pending | hit;
            n_prev_levels = cur_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_levels <= '0;
            r_pending     <= '0;
        end else if (i_accept) begin
            r_prev_levels <= n_prev_levels;
            r_pending     <= n_pending;
        end
    end

    assign o_result.pending = n_pending;
    assign o_result.irq     = group_requests(n_pending);

endmodule
`default_nettype wire

/* design/external_interrupt_edge_controller.sv */
// Top level: APB register file, stream ports and output buffering.
// Sixteen-line external interrupt edge controller. Each line watches one pin of
// port A..D chosen by a 4-bit code in the select registers (other codes read as
// low); an enabled rising or falling edge on an unmasked line sets its pending
// bit, and a clear transaction (tuser high) clears the pending bits given in its
// clear mask. Every input transaction yields one output transaction carrying the
// pending bits and seven grouped requests. Throughput is one transaction per
// clock while the output is not stalled: routing, edge detection and the
// pending update are a single level of logic between the state registers and
// the output register. A one-entry skid stage takes one more transaction while
// the output is stalled; s_axis_tready then drops until the output register
// drains. Configure only while idle.
`default_nettype none
module external_interrupt_edge_controller
    import eiec_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // APB configuration port
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [APB_ADDR_W-1:0] paddr,
    input  wire  [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input stream
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: port_a_levels, port_b_levels, port_c_levels, port_d_levels, clear_mask
    input  wire  [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: action
    input  wire                   s_axis_tuser,
    // Output stream
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // tdata: pending_flags, irq_request, one zero pad bit
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cfg     r_cfg;
    t_item    item;
    t_result  result;
    t_result  r_out;
    t_result  r_skid;
    logic     r_out_valid;
    logic     r_skid_valid;
    logic     accept;
    logic     out_take;
    logic     cfg_wr;
    t_reg_idx reg_idx;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_RISE:  r_cfg.rise   <= pwdata[LINES-1:0];
                REG_FALL:  r_cfg.fall   <= pwdata[LINES-1:0];
                REG_IEN:   r_cfg.ien    <= pwdata[LINES-1:0];
                REG_SEL0:  r_cfg.sel[0] <= pwdata[LINES-1:0];
                REG_SEL4:  r_cfg.sel[1] <= pwdata[LINES-1:0];
                REG_SEL8:  r_cfg.sel[2] <= pwdata[LINES-1:0];
                REG_SEL12: r_cfg.sel[3] <= pwdata[LINES-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_RISE:  prdata[LINES-1:0] = r_cfg.rise;
            REG_FALL:  prdata[LINES-1:0] = r_cfg.fall;
            REG_IEN:   prdata[LINES-1:0] = r_cfg.ien;
            REG_SEL0:  prdata[LINES-1:0] = r_cfg.sel[0];
            REG_SEL4:  prdata[LINES-1:0] = r_cfg.sel[1];
            REG_SEL8:  prdata[LINES-1:0] = r_cfg.sel[2];
            REG_SEL12: prdata[LINES-1:0] = r_cfg.sel[3];
            default:   prdata = '0;
        endcase
    end

    // Input transaction
    assign s_axis_tready   = !r_skid_valid;
    assign accept          = s_axis_tvalid & s_axis_tready;
    assign item.action     = s_axis_tuser;
    assign item.port_a     = s_axis_tdata[LINES-1:0];
    assign item.port_b     = s_axis_tdata[2*LINES-1:LINES];
    assign item.port_c     = s_axis_tdata[3*LINES-1:2*LINES];
    assign item.port_d     = s_axis_tdata[4*LINES-1:3*LINES];
    assign item.clear_mask = s_axis_tdata[5*LINES-1:4*LINES];

    eiec_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_item   (item),
        .o_result (result)
    );

    // Output register with skid stage
    assign out_take = r_out_valid & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= accept;
            end
        end else if (accept) begin
            // Output stalled: park the new result
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : result;
        end else if (accept) begin
            r_skid <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.irq, r_out.pending};

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the external interrupt edge controller.
module tb_top;
    import eiec_pkg::*;

    localparam int UNMAPPED_REG_IDX = 7;
    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 130;
    localparam int MAX_PRINTED      = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;
    logic                  s_axis_tvalid;
    wire                   s_axis_tready;
    // tdata: port_a_levels, port_b_levels, port_c_levels, port_d_levels, clear_mask
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // tuser: action
    logic                  s_axis_tuser;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready;
    // tdata: pending_flags, irq_request, one zero pad bit
    wire  [OUT_DATA_W-1:0] m_axis_tdata;

    external_interrupt_edge_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    typedef struct {
        bit               is_cfg;
        int               reg_idx;
        logic [LINES-1:0] reg_val;
        t_item            item;
        bit               typed;
        t_result          want;
    } t_dir_row;

    // Controller shadow: registers, stored levels and pending bits
    logic [LINES-1:0] cfg_shadow [0:6];
    logic [LINES-1:0] levels_seen;
    logic [LINES-1:0] pending_seen;

    t_result  pending_expect_q [$];
    t_dir_row dir_rows [$];

    int err_count;
    int results_checked;
    int samples_sent;
    int clears_sent;
    int reg_writes;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("MISMATCH @%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    function automatic t_result predict_pending(input t_item it);
        logic [LINES-1:0]  lv;
        logic [LINES-1:0]  hit;
        logic [CODE_W-1:0] code;
        t_result           r;
        int                n;
        lv = '0;
        if (it.action == ACT_SAMPLE) begin
            for (n = 0; n < LINES; n++) begin
                code = cfg_shadow[int'(REG_SEL0) + n / LINES_PER_SEL]
                                 [(n % LINES_PER_SEL) * CODE_W +: CODE_W];
                case (code)
                    PORT_A:  lv[n] = it.port_a[n];
                    PORT_B:  lv[n] = it.port_b[n];
                    PORT_C:  lv[n] = it.port_c[n];
                    PORT_D:  lv[n] = it.port_d[n];
                    default: lv[n] = 1'b0;
                endcase
            end
            hit = ((lv & ~levels_seen & cfg_shadow[REG_RISE]) |
                   (~lv & levels_seen & cfg_shadow[REG_FALL])) & cfg_shadow[REG_IEN];
            pending_seen = pending_seen | hit;
            levels_seen  = lv;
        end else begin
            pending_seen = pending_seen & ~it.clear_mask;
        end
        r.pending = pending_seen;
        r.irq     = {|pending_seen[15:10], |pending_seen[9:5], pending_seen[4:0]};
        return r;
    endfunction

    function automatic void add_cfg(input int idx, input logic [LINES-1:0] val);
        t_dir_row row;
        row = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_item(input logic act, input logic [LINES-1:0] a, b, c, d,
                                     clr, input bit typed, input logic [LINES-1:0] pend,
                                     input logic [IRQ_W-1:0] irq);
        t_dir_row row;
        row = '{default: '0};
        row.item.action     = act;
        row.item.port_a     = a;
        row.item.port_b     = b;
        row.item.port_c     = c;
        row.item.port_d     = d;
        row.item.clear_mask = clr;
        row.typed           = typed;
        row.want.pending    = pend;
        row.want.irq        = irq;
        dir_rows.push_back(row);
    endfunction

    task automatic apb_write(input int idx, input logic [LINES-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= {16'h0000, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx <= int'(REG_SEL12))
            cfg_shadow[idx] = val;
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic apb_check_read(input int idx);
        logic [APB_DATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(idx * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {16'h0000, cfg_shadow[idx]})
            note_mismatch($sformatf("register %0d readback", idx), rd, {16'h0000, cfg_shadow[idx]});
        @(posedge i_clk);
    endtask

    // Offer one item, hold it until accepted, then log its expected result
    task automatic push_item(input t_item it, input bit typed, input t_result want);
        t_result pred;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.clear_mask, it.port_d, it.port_c, it.port_b, it.port_a};
        s_axis_tuser  <= it.action;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        pred = predict_pending(it);
        pending_expect_q.push_back(typed ? want : pred);
        if (it.action == ACT_CLEAR)
            clears_sent++;
        else
            samples_sent++;
    endtask

    task automatic sender_gap();
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [LINES-1:0] rand_codes();
        logic [LINES-1:0] v;
        int               n;
        for (n = 0; n < LINES_PER_SEL; n++) begin
            if ($urandom_range(4) == 0)
                v[n * CODE_W +: CODE_W] = CODE_W'($urandom_range(4, 15));
            else
                v[n * CODE_W +: CODE_W] = CODE_W'($urandom_range(0, 3));
        end
        return v;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.action = ($urandom_range(99) < 25) ? ACT_CLEAR : ACT_SAMPLE;
        it.port_a = LINES'($urandom);
        it.port_b = LINES'($urandom);
        it.port_c = LINES'($urandom);
        it.port_d = LINES'($urandom);
        case ($urandom_range(7))
            0:       it.clear_mask = '1;
            1:       it.clear_mask = LINES'(1) << $urandom_range(LINES - 1);
            default: it.clear_mask = LINES'($urandom);
        endcase
        return it;
    endfunction

    // Receiver: check each result transaction, then pick the next ready
    initial begin
        t_result want;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pending_expect_q.size() == 0) begin
                    note_mismatch("result with nothing expected", 32'(m_axis_tdata), 0);
                end else begin
                    want = pending_expect_q.pop_front();
                    if (m_axis_tdata[LINES-1:0] !== want.pending)
                        note_mismatch("pending_flags", 32'(m_axis_tdata[LINES-1:0]),
                                      32'(want.pending));
                    if (m_axis_tdata[LINES +: IRQ_W] !== want.irq)
                        note_mismatch("irq_request", 32'(m_axis_tdata[LINES +: IRQ_W]),
                                      32'(want.irq));
                    results_checked++;
                end
            end
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        t_result none;
        t_item   it;
        int      p;
        int      k;
        int      r;

        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_SAMPLE;
        tx_idle_pct   = 19;
        rx_idle_pct   = 77;
        rx_hold_cycles = 0;
        none          = '0;
        for (r = 0; r <= int'(REG_SEL12); r++)
            cfg_shadow[r] = '0;
        levels_seen  = '0;
        pending_seen = '0;

        // Reset config: no edge enabled, every line on port A
        add_item(ACT_SAMPLE, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                 1, 16'h0000, 7'h00);
        add_item(ACT_CLEAR, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                 1, 16'h0000, 7'h00);
        add_cfg(REG_RISE, 16'hffff);
        add_cfg(REG_IEN, 16'hffff);
        add_item(ACT_SAMPLE, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h1234,
                 1, 16'hffff, 7'h7f);
        // Clear ignores port levels
        add_item(ACT_CLEAR, 16'h0000, 16'h5555, 16'haaaa, 16'h0f0f, 16'h0001,
                 1, 16'hfffe, 7'h7e);
        add_item(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff,
                 1, 16'h0000, 7'h00);
        add_item(ACT_SAMPLE, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 1, 16'h0000, 7'h00);
        add_cfg(REG_RISE, 16'h0000);
        add_cfg(REG_FALL, 16'hffff);
        add_item(ACT_SAMPLE, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                 1, 16'hffff, 7'h7f);
        add_item(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff,
                 1, 16'h0000, 7'h00);
        // Masked lines lose their edges
        add_cfg(REG_IEN, 16'h0021);
        add_item(ACT_SAMPLE, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 1, 16'h0000, 7'h00);
        add_item(ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 1, 16'h0021, 7'h21);
        // Pending bits survive masking and still drive requests
        add_cfg(REG_IEN, 16'h0000);
        add_item(ACT_SAMPLE, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 1, 16'h0021, 7'h21);
        add_item(ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 1, 16'h0021, 7'h21);
        add_item(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001,
                 1, 16'h0020, 7'h20);
        add_item(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0020,
                 1, 16'h0000, 7'h00);
        // Upper group drives only its own request bit
        add_cfg(REG_IEN, 16'h0400);
        add_cfg(REG_RISE, 16'hffff);
        add_item(ACT_SAMPLE, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 1, 16'h0400, 7'h40);
        add_item(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff,
                 1, 16'h0000, 7'h00);
        // Mixed routing, unused port codes, ignored register index
        add_cfg(REG_IEN, 16'hffff);
        add_cfg(REG_SEL0, 16'h3210);
        add_cfg(REG_SEL4, 16'hfe54);
        add_cfg(REG_SEL8, 16'h0123);
        add_cfg(REG_SEL12, 16'h7632);
        add_cfg(UNMAPPED_REG_IDX, 16'hffff);
        add_item(ACT_SAMPLE, 16'h1111, 16'h2222, 16'h4444, 16'h8888, 16'h0000, 0, 0, 0);
        add_item(ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
        add_item(ACT_SAMPLE, 16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
        add_item(ACT_SAMPLE, 16'h0000, 16'h0000, 16'ha5a5, 16'hffff, 16'h0000, 0, 0, 0);
        add_item(ACT_CLEAR, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h5a5a, 0, 0, 0);
        add_item(ACT_SAMPLE, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 0, 0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                settle_idle();
                apb_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
                sender_gap();
            end
        end

        for (p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 3) begin
                tx_idle_pct = 19;
                rx_idle_pct = 77;
            end else if (p < 6) begin
                tx_idle_pct = 77;
                rx_idle_pct = 19;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            settle_idle();
            apb_write(REG_RISE, (p == 1) ? 16'h0000 : (p == 2) ? 16'hffff : LINES'($urandom));
            apb_write(REG_FALL, (p == 2) ? 16'h0000 : (p == 4) ? 16'hffff : LINES'($urandom));
            apb_write(REG_IEN, (p == 5) ? 16'h0000 : (p % 2 == 0) ? 16'hffff
                                                                : LINES'($urandom));
            for (r = int'(REG_SEL0); r <= int'(REG_SEL12); r++)
                apb_write(r, (p == 3) ? 16'hffff : (p == 6) ? 16'h0000 : rand_codes());
            apb_write(UNMAPPED_REG_IDX, LINES'($urandom));
            for (r = 0; r <= int'(REG_SEL12); r++)
                apb_check_read(r);

            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Stall the output long enough to back up the input
                if (p == 6 && k == 40)
                    rx_hold_cycles = 80;
                if (p == 6 && k == 90)
                    settle_idle();
                it = rand_item();
                push_item(it, 0, none);
                sender_gap();
            end
        end

        settle_idle();
        $display("Run covered %0d sample and %0d clear transactions, %0d register writes,",
                 samples_sent, clears_sent, reg_writes);
        $display("and %0d checked results under skewed, swapped and absent back-pressure.",
                 results_checked);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
